// File: rtl/a85le_pkg.sv
`default_nettype none

package a85le_pkg;

   localparam logic CMD_DATA  = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   localparam logic [7:0] CHAR_OFFSET  = 8'd33;
   localparam logic [7:0] CHAR_ZERO    = 8'd122;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] LINE_RESET   = 8'd72;
   localparam logic [7:0] LINE_MIN     = 8'd8;

   localparam int DIGITS = 5;

   // ceil(2^38 / 85): exact quotient by 85 for every 32-bit dividend.
   localparam logic [31:0] RECIP_85    = 32'hC0C0C0C1;
   localparam int          RECIP_SHIFT = 38;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   typedef enum logic [1:0] {
      CONV_IDLE,
      CONV_RUN,
      CONV_DONE
   } conv_state_type;

   // One unit of work for the back end: a group to encode and/or a flush.
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  count;
      logic        zero_char;
      logic        flush;
   } job_type;

   // Characters ready to send, most significant digit in entry 0.
   typedef struct packed {
      logic [DIGITS-1:0][7:0] chars;
      logic [2:0]             count;
      logic                   flush;
   } burst_type;

endpackage

`default_nettype wire

// File: rtl/a85le_front.sv
`default_nettype none

module a85le_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_cmd,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic              queue_full,
   output logic                   push,
   output a85le_pkg::job_type     job
);
   import a85le_pkg::*;

   logic [23:0] group_word_ff;
   logic [23:0] group_word_in;
   logic [1:0]  group_count_ff;
   logic [1:0]  group_count_in;
   logic        accept;
   logic [31:0] full_word;
   logic [31:0] padded;

   assign req_ready = !queue_full;
   assign accept    = req_valid && !queue_full;
   assign full_word = {group_word_ff, req_data_byte};

   always_comb begin
      case (group_count_ff)
         2'd1:    padded = {group_word_ff[7:0], 24'd0};
         2'd2:    padded = {group_word_ff[15:0], 16'd0};
         2'd3:    padded = {group_word_ff[23:0], 8'd0};
         default: padded = 32'd0;
      endcase
   end

   always_comb begin
      push           = 1'b0;
      job            = '0;
      group_word_in  = group_word_ff;
      group_count_in = group_count_ff;
      if (accept) begin
         unique case (req_cmd)
            CMD_DATA: begin
               if (group_count_ff == 2'd3) begin
                  push           = 1'b1;
                  job.word       = full_word;
                  job.zero_char  = (full_word == 32'd0);
                  job.count      = (full_word == 32'd0) ? 3'd1 : 3'(DIGITS);
                  group_count_in = 2'd0;
               end else begin
                  group_word_in  = {group_word_ff[15:0], req_data_byte};
                  group_count_in = group_count_ff + 2'd1;
               end
            end
            CMD_FLUSH: begin
               // A partial group never uses the zero shorthand.
               push           = 1'b1;
               job.word       = padded;
               job.count      = (group_count_ff == 2'd0) ? 3'd0 : {1'b0, group_count_ff} + 3'd1;
               job.flush      = 1'b1;
               group_count_in = 2'd0;
            end
            default: begin
               group_count_in = group_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      group_word_ff <= group_word_in;
      if (reset) begin
         group_count_ff <= 2'd0;
      end else begin
         group_count_ff <= group_count_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/a85le_queue.sv
`default_nettype none

module a85le_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire a85le_pkg::job_type job_in,
   input  wire logic               pop,
   output logic                    full,
   output logic                    empty,
   output a85le_pkg::job_type      job_out
);
   import a85le_pkg::*;

   job_type               store_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff;
   logic [QUEUE_AW-1:0]   wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff;
   logic [QUEUE_AW-1:0]   rd_ptr_in;
   logic [QUEUE_AW:0]     fill_ff;
   logic [QUEUE_AW:0]     fill_in;
   logic                  do_push;
   logic                  do_pop;

   assign full    = (fill_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty   = (fill_ff == '0);
   assign job_out = store_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= job_in;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/a85le_conv.sv
`default_nettype none

module a85le_conv (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               queue_empty,
   input  wire a85le_pkg::job_type job,
   output logic                    pop,
   output logic                    burst_valid,
   input  wire logic               burst_ready,
   output a85le_pkg::burst_type    burst
);
   import a85le_pkg::*;

   conv_state_type         state_ff;
   conv_state_type         state_in;
   logic [31:0]            x_ff;
   logic [31:0]            x_in;
   logic [DIGITS-1:0][7:0] chars_ff;
   logic [DIGITS-1:0][7:0] chars_in;
   logic [2:0]             step_ff;
   logic [2:0]             step_in;
   logic [2:0]             count_ff;
   logic [2:0]             count_in;
   logic                   flush_ff;
   logic                   flush_in;
   logic [63:0]            product;
   logic [31:0]            quotient;
   logic [31:0]            times_85;
   logic [31:0]            remainder;
   logic [7:0]             digit_char;

   // Quotient by reciprocal multiply; 85 * q is rebuilt from shifts.
   assign product    = 64'(x_ff) * 64'(RECIP_85);
   assign quotient   = {{RECIP_SHIFT-32{1'b0}}, product[63:RECIP_SHIFT]};
   assign times_85   = (quotient << 6) + (quotient << 4) + (quotient << 2) + quotient;
   assign remainder  = x_ff - times_85;
   assign digit_char = {1'b0, remainder[6:0]} + CHAR_OFFSET;

   assign burst_valid = (state_ff == CONV_DONE);
   assign burst.chars = chars_ff;
   assign burst.count = count_ff;
   assign burst.flush = flush_ff;

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      chars_in = chars_ff;
      step_in  = step_ff;
      count_in = count_ff;
      flush_in = flush_ff;
      pop      = 1'b0;
      unique case (state_ff)
         CONV_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               x_in     = job.word;
               count_in = job.count;
               flush_in = job.flush;
               step_in  = 3'd0;
               chars_in = '0;
               if (job.zero_char) begin
                  chars_in[0] = CHAR_ZERO;
               end
               if (job.zero_char || job.count == 3'd0) begin
                  state_in = CONV_DONE;
               end else begin
                  state_in = CONV_RUN;
               end
            end
         end
         CONV_RUN: begin
            // Least significant digit comes out first and ends in the last entry.
            x_in     = quotient;
            chars_in = {chars_ff[DIGITS-2:0], digit_char};
            step_in  = step_ff + 3'd1;
            if (step_ff == 3'(DIGITS-1)) begin
               state_in = CONV_DONE;
            end
         end
         CONV_DONE: begin
            if (burst_ready) begin
               state_in = CONV_IDLE;
            end
         end
         default: begin
            state_in = CONV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      chars_ff <= chars_in;
      step_ff  <= step_in;
      count_ff <= count_in;
      flush_ff <= flush_in;
      if (reset) begin
         state_ff <= CONV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/a85le_emit.sv
`default_nettype none

module a85le_emit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [7:0]           line_length,
   input  wire logic                 burst_valid,
   output logic                      burst_ready,
   input  wire a85le_pkg::burst_type burst,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [7:0]                rsp_char_out,
   output logic                      rsp_last
);
   import a85le_pkg::*;

   burst_type  burst_ff;
   burst_type  burst_in;
   logic       busy_ff;
   logic       busy_in;
   logic [2:0] idx_ff;
   logic [2:0] idx_in;
   logic       nl_pend_ff;
   logic       nl_pend_in;
   logic [7:0] column_ff;
   logic [7:0] column_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] rsp_char_ff;
   logic [7:0] rsp_char_in;
   logic       rsp_last_ff;
   logic       rsp_last_in;
   logic [7:0] len_eff;
   logic       slot_free;
   logic [2:0] idx_next;
   logic [7:0] column_next;

   assign len_eff      = (line_length < LINE_MIN) ? LINE_MIN : line_length;
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign idx_next     = idx_ff + 3'd1;
   assign column_next  = column_ff + 8'd1;
   assign burst_ready  = !busy_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

   always_comb begin
      burst_in     = burst_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      nl_pend_in   = nl_pend_ff;
      column_in    = column_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (!busy_ff) begin
         if (burst_valid) begin
            burst_in   = burst;
            busy_in    = 1'b1;
            idx_in     = 3'd0;
            nl_pend_in = 1'b0;
         end
      end else if (!nl_pend_ff && idx_ff == burst_ff.count && column_ff == 8'd0) begin
         // A flush with nothing pending and an empty line sends nothing.
         busy_in = 1'b0;
      end else if (slot_free) begin
         rsp_valid_in = 1'b1;
         if (nl_pend_ff) begin
            rsp_char_in = CHAR_NEWLINE;
            nl_pend_in  = 1'b0;
            rsp_last_in = (idx_ff == burst_ff.count);
            busy_in     = (idx_ff != burst_ff.count);
         end else if (idx_ff < burst_ff.count) begin
            rsp_char_in = burst_ff.chars[idx_ff];
            idx_in      = idx_next;
            if (column_next >= len_eff) begin
               column_in   = 8'd0;
               nl_pend_in  = 1'b1;
               rsp_last_in = 1'b0;
            end else begin
               column_in   = column_next;
               rsp_last_in = (idx_next == burst_ff.count) &&
                             !(burst_ff.flush && column_next != 8'd0);
               busy_in     = !rsp_last_in;
            end
         end else begin
            // Closing newline for a partly filled line on flush.
            rsp_char_in = CHAR_NEWLINE;
            column_in   = 8'd0;
            rsp_last_in = 1'b1;
            busy_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      burst_ff    <= burst_in;
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         busy_ff      <= 1'b0;
         nl_pend_ff   <= 1'b0;
         column_ff    <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         nl_pend_ff   <= nl_pend_in;
         column_ff    <= column_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/ascii85_line_encoder_unit.sv
// Streaming ASCII85 encoder with line breaks. Each request is a data byte or a flush; every
// four data bytes give five characters ('z' for an all-zero group), a flush gives the digits
// of a partial group and a closing newline if the line is partly filled, and a newline
// follows every line_length characters (minimum 8). The front end takes one request per
// cycle while its two-entry job queue has room. The digit converter works on one group at
// a time (load, five digit steps through one 32x32 multiply by the reciprocal of 85,
// hand-over), while the output stage sends the previous group's characters; with no output
// stall the converter sets the pace. Results leave through a registered output that accepts
// a new character in the same cycle the previous one is taken.
`default_nettype none

module ascii85_line_encoder_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_cmd,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_char_out,
   output logic            rsp_last,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data
);
   import a85le_pkg::*;

   logic [7:0] line_length_ff;
   logic [7:0] line_length_in;
   logic       push;
   job_type    front_job;
   logic       queue_full;
   logic       queue_empty;
   logic       pop;
   job_type    head_job;
   logic       burst_valid;
   logic       burst_ready;
   burst_type  burst;

   assign line_length_in = csr_wr_en ? csr_wr_data : line_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= LINE_RESET;
      end else begin
         line_length_ff <= line_length_in;
      end
   end

   a85le_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_data_byte (req_data_byte),
      .queue_full    (queue_full),
      .push          (push),
      .job           (front_job)
   );

   a85le_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .job_in  (front_job),
      .pop     (pop),
      .full    (queue_full),
      .empty   (queue_empty),
      .job_out (head_job)
   );

   a85le_conv u_conv (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .job         (head_job),
      .pop         (pop),
      .burst_valid (burst_valid),
      .burst_ready (burst_ready),
      .burst       (burst)
   );

   a85le_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .line_length  (line_length_ff),
      .burst_valid  (burst_valid),
      .burst_ready  (burst_ready),
      .burst        (burst),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

// File: rtl/a85le_checker.sv
`default_nettype none

module a85le_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_char_out,
   input wire logic       rsp_last
);
   import a85le_pkg::*;

   logic seen_nl_ff;
   logic seen_nl_in;

   // Remembers whether the last character taken was a newline.
   assign seen_nl_in = (rsp_valid && rsp_ready) ? (rsp_char_out == CHAR_NEWLINE) : seen_nl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_nl_ff <= 1'b0;
      end else begin
         seen_nl_ff <= seen_nl_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_out) && $stable(rsp_last))
      else $error("response changed while stalled");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char_out == CHAR_NEWLINE) || (rsp_char_out == CHAR_ZERO) ||
                    (rsp_char_out >= CHAR_OFFSET && rsp_char_out <= CHAR_OFFSET + 8'd84))
      else $error("character outside the encoding alphabet");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   a_no_double_nl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_out == CHAR_NEWLINE |-> !seen_nl_ff)
      else $error("two newlines in a row");

endmodule

bind ascii85_line_encoder_unit a85le_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_char_out (rsp_char_out),
   .rsp_last     (rsp_last)
);

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps

import a85le_pkg::*;

typedef struct packed {
   logic [7:0] ch;
   logic       last;
} a85_char_type;

// Keeps its own copy of the encoder state and the queue of characters still owed by the block.
class char_scoreboard;
   logic [7:0]   line_length;
   logic [31:0]  group_word;
   int           group_count;
   logic [7:0]   column_count;
   a85_char_type expected_chars[$];
   logic [7:0]   burst[$];
   int           error_count;

   function new();
      line_length  = LINE_RESET;
      group_word   = '0;
      group_count  = 0;
      column_count = '0;
      error_count  = 0;
   endfunction

   function void set_line_length(logic [7:0] value);
      line_length = value;
   endfunction

   function int outstanding();
      return expected_chars.size();
   endfunction

   function void put_raw(logic [7:0] ch);
      burst.push_back(ch);
   endfunction

   // A newline follows the character that brings the column to the line length or past it.
   function void put_char(logic [7:0] ch);
      logic [7:0] eff_len;
      eff_len = (line_length < LINE_MIN) ? LINE_MIN : line_length;
      put_raw(ch);
      column_count = column_count + 8'd1;
      if (column_count >= eff_len) begin
         put_raw(CHAR_NEWLINE);
         column_count = '0;
      end
   endfunction

   function void put_base85(logic [31:0] word, int count);
      logic [7:0]  digit[5];
      logic [31:0] rest;
      rest = word;
      for (int i = 4; i >= 0; i--) begin
         digit[i] = 8'(rest % 32'd85);
         rest     = rest / 32'd85;
      end
      for (int i = 0; i < count; i++)
         put_char(digit[i] + CHAR_OFFSET);
   endfunction

   function void encode_request(logic cmd, logic [7:0] data);
      burst.delete();
      if (cmd == CMD_DATA) begin
         group_word  = {group_word[23:0], data};
         group_count = group_count + 1;
         if (group_count == 4) begin
            if (group_word == 32'd0)
               put_char(CHAR_ZERO);
            else
               put_base85(group_word, 5);
            group_word  = '0;
            group_count = 0;
         end
      end else begin
         // A partial group is padded with zero bytes and keeps one digit more than it has bytes.
         if (group_count != 0)
            put_base85(group_word << (8 * (4 - group_count)), group_count + 1);
         group_word  = '0;
         group_count = 0;
         if (column_count != 8'd0) begin
            put_raw(CHAR_NEWLINE);
            column_count = '0;
         end
      end
      for (int i = 0; i < burst.size(); i++)
         expected_chars.push_back('{ch: burst[i], last: (i == burst.size() - 1)});
   endfunction

   function void check_char(logic [7:0] ch, logic last);
      a85_char_type want;
      if (expected_chars.size() == 0) begin
         $display("%0t: unexpected character, expected none, actual %0d (last %0b)",
                  $time, ch, last);
         error_count++;
         return;
      end
      want = expected_chars.pop_front();
      if (ch !== want.ch) begin
         $display("%0t: char_out mismatch, expected %0d, actual %0d", $time, want.ch, ch);
         error_count++;
      end
      if (last !== want.last) begin
         $display("%0t: last mismatch, expected %0b, actual %0b", $time, want.last, last);
         error_count++;
      end
   endfunction
endclass

module testbench;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 40;

   logic       clock;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_ready;
   logic       req_cmd       = CMD_DATA;
   logic [7:0] req_data_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready     = 1'b0;
   logic [7:0] rsp_char_out;
   logic       rsp_last;
   logic       csr_wr_en     = 1'b0;
   logic [7:0] csr_wr_data   = 8'd0;

   logic       quiet         = 1'b0;
   int         stall_left    = 0;
   int         cycle_count   = 0;

   char_scoreboard ledger = new();

   ascii85_line_encoder_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_out  (rsp_char_out),
      .rsp_last      (rsp_last),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // The receiver stalls in bursts unless the run is in a quiet stretch.
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(1, 16) - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         ledger.check_char(rsp_char_out, rsp_last);
   end

   // Valid is left high on return; the next call either replaces the request or drops valid.
   task automatic send_request(logic cmd, logic [7:0] data);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_data_byte <= data;
      do
         @(posedge clock);
      while (!req_ready);
      ledger.encode_request(cmd, data);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (ledger.outstanding() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_line_length(logic [7:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ledger.set_line_length(value);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Mostly whole groups with random content, some all-zero groups, partial groups closed by a
   // flush, and the odd bare flush.
   task automatic random_stream(int items);
      int sent;
      int kind;
      int n;
      sent = 0;
      while (sent < items) begin
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            repeat (4) send_request(CMD_DATA, pick_byte());
            sent += 4;
         end else if (kind == 6) begin
            repeat (4) send_request(CMD_DATA, 8'h00);
            sent += 4;
         end else if (kind <= 8) begin
            n = $urandom_range(1, 3);
            repeat (n) send_request(CMD_DATA, pick_byte());
            send_request(CMD_FLUSH, pick_byte());
            sent += n + 1;
         end else begin
            send_request(CMD_FLUSH, pick_byte());
            sent += 1;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset line length.
      repeat (4) send_request(CMD_DATA, 8'h00);
      repeat (4) send_request(CMD_DATA, 8'hFF);
      repeat (3) send_request(CMD_DATA, 8'h00);
      send_request(CMD_DATA, 8'h01);
      send_request(CMD_FLUSH, 8'hFF);
      send_request(CMD_FLUSH, 8'h00);
      send_request(CMD_DATA, 8'hAB);
      send_request(CMD_FLUSH, 8'h00);
      repeat (3) send_request(CMD_DATA, 8'h00);
      send_request(CMD_FLUSH, 8'h00);
      send_request(CMD_DATA, 8'h80);
      send_request(CMD_DATA, 8'h7F);
      send_request(CMD_FLUSH, 8'h5A);

      write_line_length(8'd255);
      random_stream(20);
      // Leave the line well past eight characters so that the next setting cuts it short.
      repeat (8) send_request(CMD_DATA, 8'h55);

      write_line_length(LINE_MIN);
      random_stream(20);

      write_line_length(8'd3);
      random_stream(15);

      write_line_length(8'd0);
      random_stream(15);

      write_line_length(8'd100);
      random_stream(20);

      write_line_length(LINE_RESET);
      quiet <= 1'b1;
      random_stream(20);
      send_request(CMD_FLUSH, 8'h00);

      drain();
      if (ledger.error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

// File: ascii85_line_encoder_unit.f
rtl/a85le_pkg.sv
rtl/a85le_front.sv
rtl/a85le_queue.sv
rtl/a85le_conv.sv
rtl/a85le_emit.sv
rtl/ascii85_line_encoder_unit.sv
rtl/a85le_checker.sv
bench/testbench.sv
